>>> sv/sls_pkg.sv
// Shared types, constants and the probability table of the sparse logistic scorer.
`timescale 1ns / 1ps
`default_nettype none
package sls_pkg;

	localparam int FEATURE_COUNT = 1024;
	localparam int IDX_W         = 10;
	localparam int VAL_W         = 24;
	localparam int PROD_W        = 2 * VAL_W;
	localparam int FRAC_W        = 16;
	localparam int ACC_W         = 40;
	localparam int PROB_W        = 16;
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_PAIR = 1'b1;

	localparam logic [PROB_W-1:0] PROB_FULL = '1;

	typedef struct packed {
		logic                    req_type;
		logic [IDX_W-1:0]        feature_index;
		logic signed [VAL_W-1:0] fixed_value;
		logic                    last_pair;
	} req_t;

	typedef struct packed {
		logic [PROB_W-1:0]       prob_class1;
		logic [PROB_W-1:0]       prob_class0;
		logic                    predicted_class;
		logic signed [ACC_W-1:0] raw_score;
	} res_t;

	typedef logic [PROB_W-1:0] prob_lut_t [256];

	localparam logic [63:0] Q60_ONE = 64'd1 << 60;

	// series terms of exp(-1/32) in Q60, each truncated
	localparam logic [63:0] EXP_T1  = Q60_ONE / 64'd32;
	localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd64;
	localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd96;
	localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd128;
	localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd160;
	localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd192;
	localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd224;
	localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd256;
	localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd288;
	localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd320;
	localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd352;
	localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd384;
	localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd416;
	localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd448;
	localparam logic [63:0] EXP_T15 = EXP_T14 / 64'd480;
	localparam logic [63:0] EXP_T16 = EXP_T15 / 64'd512;
	localparam logic [63:0] EXP_T17 = EXP_T16 / 64'd544;
	localparam logic [63:0] EXP_T18 = EXP_T17 / 64'd576;
	localparam logic [63:0] EXP_T19 = EXP_T18 / 64'd608;
	localparam logic [63:0] EXP_T20 = EXP_T19 / 64'd640;
	localparam logic [63:0] EXP_T21 = EXP_T20 / 64'd672;
	localparam logic [63:0] EXP_T22 = EXP_T21 / 64'd704;
	localparam logic [63:0] EXP_T23 = EXP_T22 / 64'd736;

	localparam logic [63:0] EXP_POS = Q60_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
		+ EXP_T10 + EXP_T12 + EXP_T14 + EXP_T16 + EXP_T18 + EXP_T20 + EXP_T22;
	localparam logic [63:0] EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
		+ EXP_T11 + EXP_T13 + EXP_T15 + EXP_T17 + EXP_T19 + EXP_T21 + EXP_T23;
	localparam logic [63:0] EXP_HALF = EXP_POS - EXP_NEG;

	function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60] + {63'd0, p[59]};
	endfunction

	function automatic logic round_fits(logic [63:0] n, logic [63:0] e60);
		logic [127:0] p;
		logic [127:0] lim;
		lim = 128'd131070 << 60;
		if (n == 64'd0) begin
			return 1'b1;
		end
		p = {64'd0, (64'd2 * n) - 64'd1} * {64'd0, Q60_ONE + e60};
		return p <= lim;
	endfunction

	function automatic prob_lut_t build_lut();
		prob_lut_t   lut;
		logic [63:0] step;
		logic [63:0] e;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		step = q60_mul(EXP_HALF, EXP_HALF);
		e    = EXP_HALF;
		for (int j = 0; j < 128; j++) begin
			lo = 64'd0;
			hi = 64'd65535;
			for (int s = 0; s < 17; s++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (round_fits(mid, e)) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			lut[128 + j] = lo[PROB_W-1:0];
			lut[127 - j] = PROB_FULL - lo[PROB_W-1:0];
			e = q60_mul(e, step);
		end
		return lut;
	endfunction

	localparam prob_lut_t PROB_LUT = build_lut();

endpackage
`default_nettype wire

>>> sv/sls_req_if.sv
// Request channel of the sparse logistic scorer.
`timescale 1ns / 1ps
`default_nettype none
interface sls_req_if;
	logic          valid;
	logic          ready;
	sls_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/sls_res_if.sv
// Result channel of the sparse logistic scorer.
`timescale 1ns / 1ps
`default_nettype none
interface sls_res_if;
	logic          valid;
	logic          ready;
	sls_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/sparse_logistic_scorer.sv
// Sparse logistic scorer: weight memory, multiply-accumulate pipeline and result queue.
// A last pair passes stages s1, s2 and s3, then enters the result queue that drives res.
// Throughput: one request per cycle while req is ready; the 8-entry result queue sets the
// back-pressure credit. The weight memory is read once per request and written in the
// request cycle. Reset clears the accumulator at once and sweeps all 1024 entries of the
// weight memory to zero, one entry per cycle, during which req is held not ready.
`timescale 1ns / 1ps
`default_nettype none
module sparse_logistic_scorer (
	input  wire         clk,
	input  wire         arst_n,
	sls_req_if.sink     req,
	sls_res_if.source   res
);

	logic signed [sls_pkg::VAL_W-1:0] mem [sls_pkg::FEATURE_COUNT];

	logic                             clr_q;
	logic [sls_pkg::IDX_W-1:0]        clr_idx_q;

	logic                             req_fire;
	logic                             in_range;
	logic                             mem_we;
	logic [sls_pkg::IDX_W-1:0]        mem_waddr;
	logic signed [sls_pkg::VAL_W-1:0] mem_wdata;

	logic signed [sls_pkg::VAL_W-1:0] w_s1;
	logic signed [sls_pkg::VAL_W-1:0] val_s1;
	logic                             inr_s1;
	logic                             last_s1;
	logic                             v_s1;

	logic signed [sls_pkg::PROD_W-1:0] prod_s2;
	logic                              last_s2;
	logic                              v_s2;

	logic signed [sls_pkg::VAL_W-1:0]  w_eff;

	logic signed [sls_pkg::ACC_W-1:0]  acc_q;
	logic signed [sls_pkg::PROD_W-sls_pkg::FRAC_W-1:0] q_s2;
	logic signed [sls_pkg::ACC_W:0]    sum_s2;
	logic signed [sls_pkg::ACC_W-1:0]  sat_s2;

	logic signed [sls_pkg::ACC_W-1:0]  score_s3;
	logic                              rv_s3;

	logic [7:0]                        k_s3;
	logic                              fits_s3;
	sls_pkg::res_t                     res_s3;

	sls_pkg::res_t                     fifo_q [sls_pkg::FIFO_DEPTH];
	logic [sls_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [sls_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [sls_pkg::FIFO_CW-1:0]       cnt_q;
	logic [1:0]                        inflight;
	logic                              res_fire;

	// hold requests while clearing or while the result queue lacks credit
	always_comb begin
		inflight = {1'b0, v_s1 & last_s1} + {1'b0, v_s2 & last_s2} + {1'b0, rv_s3};
		req.ready = !clr_q
			&& (({1'b0, cnt_q} + {{(sls_pkg::FIFO_CW - 1){1'b0}}, inflight})
				< (sls_pkg::FIFO_CW + 1)'(sls_pkg::FIFO_DEPTH));
		req_fire = req.valid && req.ready;
		in_range = {1'b0, req.data.feature_index}
			< (sls_pkg::IDX_W + 1)'(sls_pkg::FEATURE_COUNT);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = req.data.feature_index;
		mem_wdata = req.data.fixed_value;
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (req_fire && req.data.req_type == sls_pkg::REQ_LOAD && in_range) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == sls_pkg::IDX_W'(sls_pkg::FEATURE_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (req_fire) begin
			w_s1 <= mem[req.data.feature_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rv_s3 <= 1'b0;
		end else begin
			v_s1  <= req_fire && req.data.req_type == sls_pkg::REQ_PAIR;
			v_s2  <= v_s1;
			rv_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		val_s1   <= req.data.fixed_value;
		inr_s1   <= in_range;
		last_s1  <= req.data.last_pair;
		prod_s2  <= w_eff * val_s1;
		last_s2  <= last_s1;
		score_s3 <= sat_s2;
	end

	always_comb begin
		w_eff  = inr_s1 ? w_s1 : '0;
		q_s2   = prod_s2[sls_pkg::PROD_W-1:sls_pkg::FRAC_W];
		sum_s2 = {acc_q[sls_pkg::ACC_W-1], acc_q}
			+ (sls_pkg::ACC_W + 1)'(q_s2);
		if (sum_s2[sls_pkg::ACC_W] != sum_s2[sls_pkg::ACC_W-1]) begin
			sat_s2 = sum_s2[sls_pkg::ACC_W]
				? {1'b1, {(sls_pkg::ACC_W - 1){1'b0}}}
				: {1'b0, {(sls_pkg::ACC_W - 1){1'b1}}};
		end else begin
			sat_s2 = sum_s2[sls_pkg::ACC_W-1:0];
		end
	end

	// clear after the last pair of a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= last_s2 ? '0 : sat_s2;
		end
	end

	always_comb begin
		fits_s3 = (score_s3[sls_pkg::ACC_W-1:19] == '0)
			|| (score_s3[sls_pkg::ACC_W-1:19] == '1);
		if (fits_s3) begin
			k_s3 = {~score_s3[19], score_s3[18:12]};
		end else begin
			k_s3 = score_s3[sls_pkg::ACC_W-1] ? 8'd0 : 8'd255;
		end
		res_s3.prob_class1     = sls_pkg::PROB_LUT[k_s3];
		res_s3.prob_class0     = sls_pkg::PROB_FULL - sls_pkg::PROB_LUT[k_s3];
		res_s3.predicted_class = !score_s3[sls_pkg::ACC_W-1] && (score_s3 != '0);
		res_s3.raw_score       = score_s3;
	end

	assign res_fire  = res.valid && res.ready;
	assign res.valid = cnt_q != '0;
	assign res.data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (rv_s3) begin
			fifo_q[wr_ptr_q] <= res_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (rv_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (res_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{(sls_pkg::FIFO_CW - 1){1'b0}}, rv_s3}
				- {{(sls_pkg::FIFO_CW - 1){1'b0}}, res_fire};
		end
	end

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s3 |-> cnt_q < sls_pkg::FIFO_CW'(sls_pkg::FIFO_DEPTH))
		else $error("result pushed into a full queue");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s3 |=> res.valid)
		else $error("pushed result not presented");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(v_s1 || v_s2 || rv_s3))
		else $error("request in flight during memory clear");

	a_class_prob: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s3 && res_s3.predicted_class) |-> res_s3.prob_class1[sls_pkg::PROB_W-1])
		else $error("positive score with probability below one half");
`endif

endmodule
`default_nettype wire
